FILE: hdl/delta_list_task_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Delta list task scheduler assertion macros
// Shared concurrent assertion forms, clocked on clk with reset rst_n.
// ----------------------------------------------------------------------------
`ifndef DELTA_LIST_TASK_SCHEDULER_DEFINES_SVH
`define DELTA_LIST_TASK_SCHEDULER_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define DLTS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define DLTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/dlts_pkg.sv
// ----------------------------------------------------------------------------
// Delta list task scheduler package
// Sizes, action and status codes, the list entry type and the tick divider.
// ----------------------------------------------------------------------------
package dlts_pkg;

  localparam int MAX_TASKS = 16;
  localparam int TICK_MS   = 10;

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int TIME_W = 24;
  localparam int SLOT_OUT_W = 5;

  // Division by TICK_MS is a multiplication by a rounded-up reciprocal.
  localparam int TICK_SHIFT = TIME_W + $clog2(TICK_MS);
  localparam int RECIP_W = TIME_W + 1;
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << TICK_SHIFT) + TICK_MS - 1) / TICK_MS;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_VAL[RECIP_W-1:0];
  localparam int PROD_W = TIME_W + RECIP_W;

  typedef enum logic [1:0] {
    ACT_TICK     = 2'd0,
    ACT_ADD      = 2'd1,
    ACT_DISPATCH = 2'd2,
    ACT_DELETE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_DUE   = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]        task_id;
    logic [TIME_W-1:0] delta;
    logic [TIME_W-1:0] period;
    logic [7:0]        pending;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: hdl/dlts_if.sv
// ----------------------------------------------------------------------------
// Delta list task scheduler channels
// Valid/ready channels for the action words and the result words.
// ----------------------------------------------------------------------------
interface dlts_in_if
  import dlts_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic [7:0]        task_id;
  logic [TIME_W-1:0] delay_ms;
  logic [TIME_W-1:0] period_ms;
  logic [3:0]        slot;

  modport source (output valid, action, task_id, delay_ms, period_ms, slot, input ready);
  modport sink   (input valid, action, task_id, delay_ms, period_ms, slot, output ready);
endinterface

interface dlts_out_if
  import dlts_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [7:0]            run_task_id;
  logic                  run_valid;
  logic [1:0]            status;
  logic [SLOT_OUT_W-1:0] slot_out;

  modport source (output valid, run_task_id, run_valid, status, slot_out, input ready);
  modport sink   (input valid, run_task_id, run_valid, status, slot_out, output ready);
endinterface

FILE: hdl/dlts_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module dlts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/delta_list_task_scheduler.sv
// ----------------------------------------------------------------------------
// Delta list task scheduler
// Sorted delta list of timed tasks kept in one entry RAM.
// ----------------------------------------------------------------------------
// Each action word yields one result word. A tick touches only the head entry;
// a dispatch of a due task, a delete and an add may walk the list, so their time
// grows with the number of queued tasks, and rejected actions skip the walk.
// The entry RAM is read and written back one entry at a time with a registered
// read. A result waits in the output register while the next action word is
// already accepted.
`include "delta_list_task_scheduler_defines.svh"

module delta_list_task_scheduler
  import dlts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  dlts_in_if.sink     in_chan,
  dlts_out_if.source  out_chan
);

  typedef enum logic [2:0] {
    S_IDLE, S_MULD, S_MULP, S_MULF, S_RD, S_EV, S_W2, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    M_TICK, M_ADD, M_HEAD, M_BUB, M_REM
  } mode_t;

  state_t            state_r, state_nxt;
  mode_t             mode_r, mode_nxt;
  logic [7:0]        id_r, id_nxt;
  logic [TIME_W-1:0] dms_r, dms_nxt, pms_r, pms_nxt;
  logic [TIME_W-1:0] dt_r, dt_nxt, pt_r, pt_nxt;
  logic [TIME_W-1:0] sum_r, sum_nxt, d_r, d_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt, cnt_r, cnt_nxt, pos_r, pos_nxt;
  logic              ins_r, ins_nxt;
  entry_t            carry_r, carry_nxt;
  logic [7:0]        res_id_r, res_id_nxt;
  logic              res_rv_r, res_rv_nxt;
  status_t           res_st_r, res_st_nxt;
  logic [SLOT_OUT_W-1:0] res_slot_r, res_slot_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_id_r, out_id_nxt;
  logic              out_rv_r, out_rv_nxt;
  status_t           out_st_r, out_st_nxt;
  logic [SLOT_OUT_W-1:0] out_slot_r, out_slot_nxt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  entry_t            ram_wdata, rd;
  logic [ENTRY_W-1:0] ram_rdata;

  logic              in_acc;
  logic [TIME_W:0]   sum_ext;
  logic [TIME_W-1:0] rem_dt, dec_delta;
  logic [7:0]        pend_dec;
  entry_t            tmp;

  assign rd = entry_t'(ram_rdata);
  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc = in_chan.valid && in_chan.ready;
  assign sum_ext = {1'b0, sum_r} + {1'b0, rd.delta};
  assign rem_dt = dt_r - sum_r;

  dlts_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_TASKS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;   mode_nxt = mode_r;   id_nxt = id_r;
    dms_nxt = dms_r;       pms_nxt = pms_r;     dt_nxt = dt_r;
    pt_nxt = pt_r;         sum_nxt = sum_r;     d_nxt = d_r;
    prod_nxt = prod_r;     idx_nxt = idx_r;     cnt_nxt = cnt_r;
    pos_nxt = pos_r;       ins_nxt = ins_r;     carry_nxt = carry_r;
    res_id_nxt = res_id_r; res_rv_nxt = res_rv_r;
    res_st_nxt = res_st_r; res_slot_nxt = res_slot_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_id_nxt = out_id_r; out_rv_nxt = out_rv_r;
    out_st_nxt = out_st_r; out_slot_nxt = out_slot_r;
    ram_we = 1'b0;
    ram_waddr = idx_r[IDX_W-1:0];
    ram_wdata = rd;
    ram_raddr = idx_r[IDX_W-1:0];
    dec_delta = '0;
    pend_dec = '0;
    tmp = rd;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          id_nxt = in_chan.task_id;
          dms_nxt = in_chan.delay_ms;
          pms_nxt = in_chan.period_ms;
          res_id_nxt = '0;
          res_rv_nxt = 1'b0;
          res_st_nxt = ST_OK;
          res_slot_nxt = '0;
          idx_nxt = '0;
          case (action_t'(in_chan.action))
            ACT_TICK: begin
              mode_nxt = M_TICK;
              state_nxt = (cnt_r == '0) ? S_FIN : S_RD;
            end
            ACT_ADD: begin
              if (cnt_r >= CNT_W'(MAX_TASKS)) begin
                res_st_nxt = ST_FULL;
                res_slot_nxt = SLOT_OUT_W'(MAX_TASKS);
                state_nxt = S_FIN;
              end else begin
                mode_nxt = M_ADD;
                state_nxt = S_MULD;
              end
            end
            ACT_DISPATCH: begin
              mode_nxt = M_HEAD;
              if (cnt_r == '0) begin
                res_st_nxt = ST_NOT_DUE;
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_RD;
              end
            end
            default: begin
              mode_nxt = M_REM;
              if (CNT_W'(in_chan.slot) >= cnt_r) begin
                res_st_nxt = ST_EMPTY;
                state_nxt = S_FIN;
              end else begin
                idx_nxt = CNT_W'(in_chan.slot) + CNT_W'(1);
                state_nxt = S_RD;
              end
            end
          endcase
        end
      end
      S_MULD: begin
        prod_nxt = PROD_W'(dms_r) * PROD_W'(RECIP);
        state_nxt = S_MULP;
      end
      S_MULP: begin
        dt_nxt = TIME_W'(prod_r >> TICK_SHIFT);
        prod_nxt = PROD_W'(pms_r) * PROD_W'(RECIP);
        state_nxt = S_MULF;
      end
      S_MULF: begin
        pt_nxt = TIME_W'(prod_r >> TICK_SHIFT);
        sum_nxt = '0;
        ins_nxt = 1'b0;
        state_nxt = S_RD;
      end
      S_RD: begin
        if (idx_r < cnt_r || mode_r == M_TICK || mode_r == M_HEAD) begin
          state_nxt = S_EV;
        end else begin
          state_nxt = S_FIN;
          case (mode_r)
            M_ADD: begin
              ram_we = 1'b1;
              if (ins_r) begin
                ram_wdata = carry_r;
              end else begin
                ram_wdata = '{task_id: id_r, delta: rem_dt, period: pt_r, pending: '0};
                pos_nxt = idx_r;
              end
              cnt_nxt = cnt_r + CNT_W'(1);
              res_slot_nxt = SLOT_OUT_W'(ins_r ? pos_r : idx_r);
            end
            M_BUB: begin
              ram_we = 1'b1;
              ram_waddr = IDX_W'(cnt_r - CNT_W'(1));
              ram_wdata = '{task_id: carry_r.task_id, delta: d_r,
                            period: carry_r.period, pending: '0};
            end
            default: begin
              cnt_nxt = cnt_r - CNT_W'(1);
            end
          endcase
        end
      end
      S_EV: begin
        case (mode_r)
          M_TICK: begin
            dec_delta = (rd.delta != '0) ? rd.delta - TIME_W'(1) : rd.delta;
            tmp.delta = dec_delta;
            if (dec_delta == '0) begin
              if (rd.pending != 8'hFF) begin
                tmp.pending = rd.pending + 8'd1;
              end
              if (rd.period != '0) begin
                tmp.delta = rd.period;
              end
            end
            ram_we = 1'b1;
            ram_wdata = tmp;
            state_nxt = S_FIN;
          end
          M_HEAD: begin
            if (rd.pending == '0 && rd.delta != '0) begin
              res_st_nxt = ST_NOT_DUE;
              state_nxt = S_FIN;
            end else begin
              res_id_nxt = rd.task_id;
              res_rv_nxt = 1'b1;
              pend_dec = (rd.pending != '0) ? rd.pending - 8'd1 : '0;
              idx_nxt = CNT_W'(1);
              if (rd.period == '0) begin
                mode_nxt = M_REM;
                state_nxt = S_RD;
              end else if (pend_dec == '0 && cnt_r > CNT_W'(1)) begin
                carry_nxt = '{task_id: rd.task_id, delta: rd.period,
                              period: rd.period, pending: '0};
                d_nxt = rd.period;
                mode_nxt = M_BUB;
                state_nxt = S_RD;
              end else begin
                tmp.pending = pend_dec;
                ram_we = 1'b1;
                ram_wdata = tmp;
                state_nxt = S_FIN;
              end
            end
          end
          M_BUB: begin
            ram_we = 1'b1;
            if (d_r >= rd.delta) begin
              d_nxt = d_r - rd.delta;
              ram_waddr = IDX_W'(idx_r - CNT_W'(1));
              idx_nxt = idx_r + CNT_W'(1);
              state_nxt = S_RD;
            end else begin
              tmp.delta = rd.delta - d_r;
              ram_wdata = tmp;
              state_nxt = S_W2;
            end
          end
          M_REM: begin
            ram_we = 1'b1;
            ram_waddr = IDX_W'(idx_r - CNT_W'(1));
            idx_nxt = idx_r + CNT_W'(1);
            state_nxt = S_RD;
          end
          default: begin
            idx_nxt = idx_r + CNT_W'(1);
            state_nxt = S_RD;
            if (ins_r) begin
              ram_we = 1'b1;
              ram_wdata = carry_r;
              carry_nxt = rd;
            end else if (sum_ext <= {1'b0, dt_r}) begin
              sum_nxt = sum_ext[TIME_W-1:0];
            end else begin
              ram_we = 1'b1;
              ram_wdata = '{task_id: id_r, delta: rem_dt, period: pt_r, pending: '0};
              tmp.delta = rd.delta - rem_dt;
              carry_nxt = tmp;
              ins_nxt = 1'b1;
              pos_nxt = idx_r;
            end
          end
        endcase
      end
      S_W2: begin
        ram_we = 1'b1;
        ram_waddr = IDX_W'(idx_r - CNT_W'(1));
        ram_wdata = '{task_id: carry_r.task_id, delta: d_r,
                      period: carry_r.period, pending: '0};
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_id_nxt = res_id_r;
          out_rv_nxt = res_rv_r;
          out_st_nxt = res_st_r;
          out_slot_nxt = res_slot_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r <= M_TICK;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r <= mode_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    id_r <= id_nxt;         dms_r <= dms_nxt;     pms_r <= pms_nxt;
    dt_r <= dt_nxt;         pt_r <= pt_nxt;       sum_r <= sum_nxt;
    d_r <= d_nxt;           prod_r <= prod_nxt;   idx_r <= idx_nxt;
    pos_r <= pos_nxt;       ins_r <= ins_nxt;     carry_r <= carry_nxt;
    res_id_r <= res_id_nxt; res_rv_r <= res_rv_nxt;
    res_st_r <= res_st_nxt; res_slot_r <= res_slot_nxt;
    out_id_r <= out_id_nxt; out_rv_r <= out_rv_nxt;
    out_st_r <= out_st_nxt; out_slot_r <= out_slot_nxt;
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.run_task_id = out_id_r;
  assign out_chan.run_valid = out_rv_r;
  assign out_chan.status = out_st_r;
  assign out_chan.slot_out = out_slot_r;

  `DLTS_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(MAX_TASKS), "task count above capacity")
  `DLTS_ASSERT_SAME(a_we_state, ram_we, state_r == S_RD || state_r == S_EV || state_r == S_W2, "entry write outside list walk")
  `DLTS_ASSERT_NEXT(a_acc_busy, in_acc, state_r != S_IDLE, "accepted word did not start work")
  `DLTS_ASSERT_SAME(a_out_from_fin, $rose(out_valid_r), $past(state_r) == S_FIN, "result word not from finish")

endmodule

FILE: verif/delta_list_task_scheduler_if_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler test channel notes
// The block's channel interfaces come from the RTL; this file holds the
// result word type used by the test.
// ----------------------------------------------------------------------------
package dlts_tb_pkg;
  import dlts_pkg::*;

  typedef struct {
    logic [7:0]            run_task_id;
    logic                  run_valid;
    status_t               status;
    logic [SLOT_OUT_W-1:0] slot_out;
  } sched_result_t;
endpackage

FILE: verif/delta_list_task_scheduler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta list task scheduler regression
// Drives tick, add, dispatch and delete words with random gaps and back
// pressure, predicts each result word from a local copy of the list and
// compares every field in order.
// ----------------------------------------------------------------------------
module delta_list_task_scheduler_test;
  import dlts_pkg::*;
  import dlts_tb_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic clk;
  logic rst_n;

  dlts_in_if  in_chan ();
  dlts_out_if out_chan ();

  delta_list_task_scheduler dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  logic [7:0]        q_task [MAX_TASKS];
  logic [TIME_W-1:0] q_delta [MAX_TASKS];
  logic [TIME_W-1:0] q_period [MAX_TASKS];
  logic [7:0]        q_pending [MAX_TASKS];
  int                q_count;

  sched_result_t expected_results[$];
  int mismatches;
  int results_seen;
  int dispatches_run;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("delta_list_task_scheduler regression: fail");
        $finish;
      end
    end
  end

  function automatic void move_entry(int dst, int src);
    q_task[dst]    = q_task[src];
    q_delta[dst]   = q_delta[src];
    q_period[dst]  = q_period[src];
    q_pending[dst] = q_pending[src];
  endfunction

  function automatic void drop_entry(int pos);
    for (int i = pos + 1; i < q_count; i++) move_entry(i - 1, i);
    q_count--;
  endfunction

  // Works out the result of one word and updates the local list.
  function automatic sched_result_t schedule_step(action_t act, logic [7:0] id,
                                                  logic [23:0] dms, logic [23:0] pms,
                                                  logic [3:0] slot);
    sched_result_t r;
    logic [23:0] dt, pt, sum, d, p;
    logic [7:0] t, rp;
    int pos;
    r.run_task_id = '0;
    r.run_valid = 1'b0;
    r.status = ST_OK;
    r.slot_out = '0;
    case (act)
      ACT_TICK: begin
        if (q_count > 0) begin
          if (q_delta[0] != 0) q_delta[0]--;
          if (q_delta[0] == 0) begin
            if (q_pending[0] != 8'd255) q_pending[0]++;
            if (q_period[0] != 0) q_delta[0] = q_period[0];
          end
        end
      end
      ACT_ADD: begin
        if (q_count >= MAX_TASKS) begin
          r.status = ST_FULL;
          r.slot_out = SLOT_OUT_W'(MAX_TASKS);
        end else begin
          dt = dms / TICK_MS;
          pt = pms / TICK_MS;
          sum = '0;
          pos = 0;
          while (pos < q_count && {1'b0, sum} + {1'b0, q_delta[pos]} <= {1'b0, dt}) begin
            sum += q_delta[pos];
            pos++;
          end
          for (int i = q_count; i > pos; i--) move_entry(i, i - 1);
          if (pos < q_count) q_delta[pos + 1] = q_delta[pos + 1] - (dt - sum);
          q_task[pos] = id;
          q_delta[pos] = dt - sum;
          q_period[pos] = pt;
          q_pending[pos] = '0;
          q_count++;
          r.slot_out = SLOT_OUT_W'(pos);
        end
      end
      ACT_DISPATCH: begin
        if (q_count == 0 || (q_pending[0] == 0 && q_delta[0] != 0)) begin
          r.status = ST_NOT_DUE;
        end else begin
          r.run_task_id = q_task[0];
          r.run_valid = 1'b1;
          if (q_pending[0] != 0) q_pending[0]--;
          if (q_period[0] == 0) begin
            drop_entry(0);
          end else if (q_pending[0] == 0 && q_count > 1) begin
            t = q_task[0];
            p = q_period[0];
            rp = q_pending[0];
            d = p;
            q_delta[0] = p;
            for (int i = 1; i < q_count; i++) begin
              if (d >= q_delta[i]) begin
                d -= q_delta[i];
                move_entry(i - 1, i);
                q_task[i] = t;
                q_delta[i] = d;
                q_period[i] = p;
                q_pending[i] = rp;
              end else begin
                q_delta[i] -= d;
                break;
              end
            end
          end
        end
      end
      default: begin
        if (slot >= q_count) r.status = ST_EMPTY;
        else drop_entry(slot);
      end
    endcase
    return r;
  endfunction

  task automatic send_word(action_t act, logic [7:0] id, logic [23:0] dms,
                           logic [23:0] pms, logic [3:0] slot, int max_gap = 11);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.action    <= act;
    in_chan.task_id   <= id;
    in_chan.delay_ms  <= dms;
    in_chan.period_ms <= pms;
    in_chan.slot      <= slot;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    expected_results.push_back(schedule_step(act, id, dms, pms, slot));
    if (act == ACT_DISPATCH && expected_results[$].run_valid) dispatches_run++;
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, compare every accepted word with the oldest
  // prediction.
  initial begin
    sched_result_t exp_r;
    int stall;
    out_chan.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at cycle %0d", cycles);
      end else begin
        exp_r = expected_results.pop_front();
        if (out_chan.run_task_id !== exp_r.run_task_id || out_chan.run_valid !== exp_r.run_valid
            || out_chan.status !== exp_r.status || out_chan.slot_out !== exp_r.slot_out) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected id %0d valid %0d status %0d slot %0d, got %0d %0d %0d %0d",
                     exp_r.run_task_id, exp_r.run_valid, exp_r.status, exp_r.slot_out,
                     out_chan.run_task_id, out_chan.run_valid, out_chan.status,
                     out_chan.slot_out);
        end
      end
    end
  end

  task automatic test_directed();
    send_word(ACT_TICK, 8'd1, '0, '0, 4'd0);
    send_word(ACT_DISPATCH, 8'd1, '0, '0, 4'd0);
    send_word(ACT_DELETE, 8'd1, '0, '0, 4'd15);
    send_word(ACT_ADD, 8'd0, 24'd0, 24'd0, 4'd0);
    send_word(ACT_ADD, 8'd255, 24'hFFFFFF, 24'hFFFFFF, 4'd0);
    send_word(ACT_ADD, 8'd7, 24'd25, 24'd9, 4'd0);
    send_word(ACT_ADD, 8'd8, 24'd30, 24'd20, 4'd0);
    send_word(ACT_DISPATCH, 8'd0, '0, '0, 4'd0);
    send_word(ACT_TICK, 8'd0, '0, '0, 4'd0);
    send_word(ACT_TICK, 8'd0, '0, '0, 4'd0);
    send_word(ACT_TICK, 8'd0, '0, '0, 4'd0);
    send_word(ACT_DISPATCH, 8'd0, '0, '0, 4'd0);
    send_word(ACT_DISPATCH, 8'd0, '0, '0, 4'd0);
    send_word(ACT_DELETE, 8'd0, '0, '0, 4'd1);
    send_word(ACT_DELETE, 8'd0, '0, '0, 4'd0);
    while (q_count < MAX_TASKS)
      send_word(ACT_ADD, 8'($urandom), 24'($urandom_range(0, 200)), 24'($urandom_range(0, 80)),
                4'd0, 0);
    send_word(ACT_ADD, 8'd9, 24'd5, 24'd5, 4'd0);
    send_word(ACT_DELETE, 8'd0, '0, '0, 4'd15);
    send_word(ACT_DELETE, 8'd0, '0, '0, 4'd15);
  endtask

  // Pending saturation: a zero-delta head ticked past 255 times.
  task automatic test_pending_saturation();
    while (q_count > 0) send_word(ACT_DELETE, 8'd0, '0, '0, 4'd0, 0);
    send_word(ACT_ADD, 8'd42, 24'd3, 24'd0, 4'd0);
    repeat (260) send_word(ACT_TICK, 8'd0, '0, '0, 4'd0, 1);
    repeat (3) send_word(ACT_DISPATCH, 8'd0, '0, '0, 4'd0);
    send_word(ACT_DELETE, 8'd0, '0, '0, 4'd0);
  endtask

  task automatic test_random(int count);
    int sel;
    logic [23:0] dms, pms;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) wait_drained();
      sel = $urandom_range(0, 99);
      dms = ($urandom_range(0, 15) == 0) ? 24'($urandom) : 24'($urandom_range(0, 120));
      pms = ($urandom_range(0, 15) == 0) ? 24'($urandom)
          : ($urandom_range(0, 2) == 0) ? 24'($urandom_range(0, 9)) : 24'($urandom_range(10, 90));
      if (sel < 45) send_word(ACT_TICK, 8'($urandom), dms, pms, 4'($urandom));
      else if (sel < 65) send_word(ACT_ADD, 8'($urandom), dms, pms, 4'($urandom));
      else if (sel < 88) send_word(ACT_DISPATCH, 8'($urandom), dms, pms, 4'($urandom));
      else send_word(ACT_DELETE, 8'($urandom), dms, pms,
                     4'($urandom_range(0, (q_count > 0 && sel < 96) ? q_count - 1 : 15)));
    end
  endtask

  initial begin
    int drain;
    mismatches = 0;
    results_seen = 0;
    dispatches_run = 0;
    q_count = 0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.action = ACT_TICK;
    in_chan.task_id = '0;
    in_chan.delay_ms = '0;
    in_chan.period_ms = '0;
    in_chan.slot = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_pending_saturation();
    test_random(820);
    wait_drained();
    drain = 0;
    while (drain < 100) begin
      @(posedge clk);
      drain++;
    end
    $display("Covered %0d result words with %0d successful dispatches.",
             results_seen, dispatches_run);
    $display("Actions: tick, add up to a full list, dispatch, delete, pending saturation.");
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("delta_list_task_scheduler regression: pass");
    end else begin
      $display("delta_list_task_scheduler regression: fail");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+hdl
hdl/dlts_pkg.sv
hdl/dlts_if.sv
hdl/dlts_ram.sv
hdl/delta_list_task_scheduler.sv
verif/delta_list_task_scheduler_if_tb.sv
verif/delta_list_task_scheduler_test.sv
